FILE: design/b2d_pkg.sv
`default_nettype none

package b2d_pkg;

   localparam int unsigned DIGITS     = 5;
   localparam int unsigned PLACE_W    = $clog2(DIGITS);
   localparam int unsigned VALUE_W    = 16;
   localparam int unsigned WIDE_W     = VALUE_W + 1;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned CHAR_W     = 6;

   typedef logic [PLACE_W-1:0] place_type;
   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [CHAR_W-1:0]  char_type;

   localparam place_type LAST_PLACE = place_type'(DIGITS - 1);
   localparam char_type  CHAR_SPACE = 6'd32;
   localparam char_type  CHAR_ZERO  = 6'd48;

   // value still to be printed plus whether a nonzero digit has been seen
   typedef struct packed {
      logic [VALUE_W-1:0] rest;
      logic               shown;
   } token_type;

   function automatic logic [WIDE_W-1:0] digit_weight(input place_type place);
      logic [WIDE_W-1:0] w;
      unique case (place)
         3'd0:    w = 17'd10000;
         3'd1:    w = 17'd1000;
         3'd2:    w = 17'd100;
         3'd3:    w = 17'd10;
         default: w = 17'd1;
      endcase
      return w;
   endfunction

   // nine times the largest weight still fits in WIDE_W bits
   function automatic logic [WIDE_W-1:0] place_multiple(input place_type place,
                                                        input digit_type digit);
      return digit_weight(place) * {{(WIDE_W-DIGIT_W){1'b0}}, digit};
   endfunction

endpackage

`default_nettype wire

FILE: design/binary_to_decimal_blanked.sv
`default_nettype none

// Converts a 16-bit unsigned value into five ASCII characters, most significant
// digit first, with leading zeros shown as spaces (zero prints as four spaces and
// '0'); the fifth character carries rsp_last. The value walks down a row of five
// digit cells, one per decimal place; the cell holding the oldest value drives the
// result port and hands the remainder to its neighbor on each transfer. One
// character leaves per cycle while rsp_stall is low; the next value waits in the
// first cell and starts as soon as the previous units digit is taken. When the row
// is empty, the first character of a value is available the cycle after its input
// transfer.
module binary_to_decimal_blanked (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [b2d_pkg::VALUE_W-1:0]   req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output b2d_pkg::char_type                  rsp_character,
   output logic                               rsp_last
);
   import b2d_pkg::*;

   logic      [DIGITS-1:0] valid;
   logic      [DIGITS-1:0] load;
   logic      [DIGITS-1:0] advance;
   logic      [DIGITS-1:0] emit;
   token_type              token_in   [DIGITS];
   token_type              token_next [DIGITS];
   char_type               cell_char  [DIGITS];
   logic                   take;
   logic                   req_take;

   for (genvar k = 0; k < DIGITS; k++) begin : g_cell
      b2d_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .place      (place_type'(k)),
         .load       (load[k]),
         .token_in   (token_in[k]),
         .advance    (advance[k]),
         .valid      (valid[k]),
         .token_next (token_next[k]),
         .character  (cell_char[k])
      );
   end

   // the oldest value sits furthest down the row
   always_comb begin
      logic seen;
      seen = 1'b0;
      emit = '0;
      for (int k = DIGITS - 1; k >= 0; k--) begin
         if (valid[k] && !seen) begin
            emit[k] = 1'b1;
         end
         seen = seen | valid[k];
      end
   end

   assign rsp_valid = |valid;
   assign take      = rsp_valid & ~rsp_stall;
   assign advance   = emit & {DIGITS{take}};
   assign req_stall = valid[0] & ~advance[0];
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      load[0]        = req_take;
      token_in[0]    = '{rest: req_value, shown: 1'b0};
      for (int k = 1; k < DIGITS; k++) begin
         load[k]     = advance[k-1];
         token_in[k] = token_next[k-1];
      end
   end

   always_comb begin
      rsp_character = CHAR_SPACE;
      for (int k = 0; k < DIGITS; k++) begin
         if (emit[k]) begin
            rsp_character = cell_char[k];
         end
      end
   end

   assign rsp_last = emit[DIGITS-1];

`ifndef SYNTHESIS
   a_units_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_character != CHAR_SPACE)
      else $error("units character blanked");

   a_two_values_max: assert property (@(posedge clock) disable iff (reset)
      $countones(valid) <= 2)
      else $error("more than two values in the cell row");

   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("character run broken before last");

   a_load_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid[0] && rsp_valid)
      else $error("accepted value missing from first cell");
`endif

endmodule

`default_nettype wire

FILE: design/b2d_cell.sv
`default_nettype none

module b2d_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire b2d_pkg::place_type place,
   input  wire logic               load,
   input  wire b2d_pkg::token_type token_in,
   input  wire logic               advance,
   output logic                    valid,
   output b2d_pkg::token_type      token_next,
   output b2d_pkg::char_type       character
);
   import b2d_pkg::*;

   logic              valid_ff, valid_in;
   token_type         token_ff;
   logic [WIDE_W-1:0] rest_wide;
   logic [WIDE_W-1:0] remainder;
   digit_type         digit;
   logic              shown;

   assign valid_in = load | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         token_ff <= token_in;
      end
   end

   // parallel compares against the nine multiples of this place's weight
   always_comb begin
      rest_wide = {1'b0, token_ff.rest};
      digit     = '0;
      for (int d = 1; d < 10; d++) begin
         if (rest_wide >= place_multiple(place, digit_type'(d))) begin
            digit = digit_type'(d);
         end
      end
      remainder = rest_wide - place_multiple(place, digit);
      shown     = token_ff.shown | (digit != '0) | (place == LAST_PLACE);
   end

   assign valid            = valid_ff;
   assign token_next.rest  = remainder[VALUE_W-1:0];
   assign token_next.shown = shown;
   assign character        = shown ? CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit}
                                   : CHAR_SPACE;

endmodule

`default_nettype wire

FILE: sim/b2d_checker.sv
`timescale 1ns / 100ps

module b2d_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic                        req_stall,
   input  wire logic [b2d_pkg::VALUE_W-1:0] req_value,
   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   input  wire b2d_pkg::char_type           rsp_character,
   input  wire logic                        rsp_last,
   output int unsigned                      pending_chars,
   output int unsigned                      checked_chars,
   output int unsigned                      failure_count
);
   import b2d_pkg::*;

   typedef struct packed {
      char_type character;
      logic     last;
   } glyph_type;

   glyph_type expected_glyphs[$];

   // decimal places, most significant first
   localparam int unsigned PLACE_WEIGHT [DIGITS] = '{10000, 1000, 100, 10, 1};

   function automatic void queue_decimal_glyphs(input logic [VALUE_W-1:0] value);
      int unsigned rest;
      int unsigned digit;
      bit          shown;
      glyph_type   g;
      rest  = value;
      shown = 1'b0;
      for (int k = 0; k < DIGITS; k++) begin
         digit = rest / PLACE_WEIGHT[k];
         rest  = rest % PLACE_WEIGHT[k];
         // units place always prints, even for zero
         if (digit != 0 || k == DIGITS - 1)
            shown = 1'b1;
         g.character = shown ? char_type'(CHAR_ZERO + digit) : CHAR_SPACE;
         g.last      = (k == DIGITS - 1);
         expected_glyphs.push_back(g);
      end
   endfunction

   initial begin
      pending_chars = 0;
      checked_chars = 0;
      failure_count = 0;
   end

   always @(posedge clock) begin
      glyph_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            queue_decimal_glyphs(req_value);
         if (rsp_valid && !rsp_stall) begin
            if (expected_glyphs.size() == 0) begin
               $display("%0t: unexpected transfer char=%0d last=%0b", $time,
                        rsp_character, rsp_last);
               failure_count <= failure_count + 1;
            end else begin
               want = expected_glyphs.pop_front();
               if (rsp_character !== want.character || rsp_last !== want.last) begin
                  $display("%0t: mismatch expected char=%0d last=%0b, got char=%0d last=%0b",
                           $time, want.character, want.last, rsp_character, rsp_last);
                  failure_count <= failure_count + 1;
               end
               checked_chars <= checked_chars + 1;
            end
         end
         pending_chars <= expected_glyphs.size();
      end
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import b2d_pkg::*;

   localparam int unsigned RANDOM_VALUES = 250;

   localparam int unsigned STALL_NONE     = 0;
   localparam int unsigned STALL_LIGHT    = 1;
   localparam int unsigned STALL_PERIODIC = 2;
   localparam int unsigned STALL_HEAVY    = 3;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic [VALUE_W-1:0]   req_value = '0;
   logic                 rsp_stall = 1'b0;
   logic                 req_stall;
   logic                 rsp_valid;
   char_type             rsp_character;
   logic                 rsp_last;

   int unsigned pending_chars;
   int unsigned checked_chars;
   int unsigned failure_count;
   int unsigned values_sent;
   int unsigned zero_values;

   binary_to_decimal_blanked i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   b2d_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .pending_chars (pending_chars),
      .checked_chars (checked_chars),
      .failure_count (failure_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver stall: switches between no stall, light random, a fixed
   // period and heavy random at random intervals
   int unsigned stall_mode;
   int unsigned stall_left;
   int unsigned stall_phase;
   initial begin
      stall_mode  = STALL_NONE;
      stall_left  = 40;
      stall_phase = 0;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(STALL_NONE, STALL_HEAVY);
         stall_left <= $urandom_range(20, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_phase <= (stall_phase == 4) ? 0 : stall_phase + 1;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 9) < 3);
         STALL_PERIODIC: rsp_stall <= (stall_phase == 1 || stall_phase == 3);
         default:        rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   // sender state: bursts of items separated by idle gaps
   int unsigned burst_left;

   // called at a rising edge; returns at the edge of the transfer
   task automatic send_value(input logic [VALUE_W-1:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      values_sent++;
      if (value == 0)
         zero_values++;
   endtask

   initial begin
      logic [VALUE_W-1:0] directed [24];
      logic [VALUE_W-1:0] value;
      directed = '{
         16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
         16'd9999, 16'd10000, 16'd65535, 16'd65534, 16'd10001, 16'd1009,
         16'd40000, 16'd60009, 16'd305, 16'd7, 16'd42, 16'h8000, 16'h5555,
         16'hAAAA, 16'h0FFF, 16'd0
      };
      values_sent = 0;
      zero_values = 0;
      burst_left  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_value(directed[i]);

      // spread over digit counts so blanking of every width shows up often
      repeat (RANDOM_VALUES) begin
         case ($urandom_range(0, 6))
            0:       value = VALUE_W'($urandom_range(0, 9));
            1:       value = VALUE_W'($urandom_range(10, 99));
            2:       value = VALUE_W'($urandom_range(100, 999));
            3:       value = VALUE_W'($urandom_range(1000, 9999));
            default: value = VALUE_W'($urandom_range(0, 65535));
         endcase
         send_value(value);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_chars != 0);
      repeat (20) @(posedge clock);

      $display("Converted %0d values (%0d directed, %0d zero) into %0d checked characters",
               values_sent, $size(directed), zero_values, checked_chars);
      $display("Sender bursts and receiver stall modes varied throughout; %0d failures",
               failure_count);
      if (failure_count == 0 && pending_chars == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d characters outstanding", pending_chars);
      $display("Some tests failed");
      $finish;
   end

endmodule

FILE: filelist.f
design/b2d_pkg.sv
design/b2d_cell.sv
design/binary_to_decimal_blanked.sv
sim/b2d_checker.sv
sim/testbench.sv
